>>> design/cwv_pkg.sv
// Shared types, constants and lookup functions for the coupled waveguide voice.
package cwv_pkg;

	localparam int TUNNEL_COUNT = 4;
	localparam int DELAY_DEPTH  = 4096;
	localparam int TUN_W        = $clog2(TUNNEL_COUNT);
	localparam int POS_W        = $clog2(DELAY_DEPTH);
	localparam int MEM_DEPTH    = TUNNEL_COUNT * DELAY_DEPTH;
	localparam int MEM_AW       = $clog2(MEM_DEPTH);
	localparam int SAMPLE_W     = 16;
	localparam int WD_W         = 34;
	localparam int Q_ONE        = 32768;
	localparam int SAT_LIM      = 1048576;
	localparam int TANH_TOP     = 131072;
	localparam int FB_CAP       = 32178;

	// configuration register indexes
	localparam logic CFG_SAMPLE_RATE = 1'b0;
	localparam logic CFG_NOISE_SEED  = 1'b1;

	localparam logic [17:0] SR_RESET   = 18'd48000;
	localparam logic [31:0] SEED_RESET = 32'd2463534242;

	// working word for all fixed-point intermediates
	typedef logic signed [WD_W-1:0] wd_t;

	// tanh over [0,4] in steps of 1/8, Q1.15
	function automatic logic [14:0] tanh_tab(input logic [5:0] idx);
		case (idx)
			6'd0:  return 15'd0;
			6'd1:  return 15'd4075;
			6'd2:  return 15'd8026;
			6'd3:  return 15'd11743;
			6'd4:  return 15'd15143;
			6'd5:  return 15'd18173;
			6'd6:  return 15'd20813;
			6'd7:  return 15'd23079;
			6'd8:  return 15'd24956;
			6'd9:  return 15'd26519;
			6'd10: return 15'd27797;
			6'd11: return 15'd28830;
			6'd12: return 15'd29660;
			6'd13: return 15'd30322;
			6'd14: return 15'd30847;
			6'd15: return 15'd31262;
			6'd16: return 15'd31589;
			6'd17: return 15'd31846;
			6'd18: return 15'd32048;
			6'd19: return 15'd32205;
			6'd20: return 15'd32329;
			6'd21: return 15'd32426;
			6'd22: return 15'd32502;
			6'd23: return 15'd32560;
			6'd24: return 15'd32606;
			6'd25: return 15'd32642;
			6'd26: return 15'd32670;
			6'd27: return 15'd32691;
			6'd28: return 15'd32708;
			6'd29: return 15'd32722;
			6'd30: return 15'd32732;
			6'd31: return 15'd32740;
			default: return 15'd32746;
		endcase
	endfunction

	// tunnel length ratios
	function automatic wd_t len_ratio(input logic [TUN_W-1:0] ti);
		case (ti)
			2'd0:    return wd_t'(13435);
			2'd1:    return wd_t'(23265);
			2'd2:    return wd_t'(40305);
			default: return wd_t'(63242);
		endcase
	endfunction

	// 65536/(i+1), exact floor for nonnegative values below 2^15
	function automatic wd_t recip(input logic [TUN_W-1:0] ti);
		case (ti)
			2'd0:    return wd_t'(65536);
			2'd1:    return wd_t'(32768);
			2'd2:    return wd_t'(21846);
			default: return wd_t'(16384);
		endcase
	endfunction

	// scatter gain per tunnel: 28180 - 2294*i
	function automatic wd_t scat_gain(input logic [TUN_W-1:0] ti);
		case (ti)
			2'd0:    return wd_t'(28180);
			2'd1:    return wd_t'(25886);
			2'd2:    return wd_t'(23592);
			default: return wd_t'(21298);
		endcase
	endfunction

	function automatic logic signed [15:0] sat16(input wd_t x);
		if (x > wd_t'(Q_ONE - 1)) return 16'sh7fff;
		if (x < -wd_t'(Q_ONE)) return 16'sh8000;
		return x[15:0];
	endfunction

	function automatic wd_t sat20(input wd_t x);
		if (x > wd_t'(SAT_LIM - 1)) return wd_t'(SAT_LIM - 1);
		if (x < -wd_t'(SAT_LIM)) return -wd_t'(SAT_LIM);
		return x;
	endfunction

endpackage

>>> design/cwv_if.sv
// Valid/ready channel interfaces for the voice input ticks and output samples.
interface cwv_in_if;
	logic        valid;
	logic        ready;
	logic        note_on;
	logic [22:0] fundamental_hz;
	logic [15:0] depth;
	logic [15:0] dread;
	logic [15:0] expression;
	logic [15:0] velocity;

	modport source(output valid, note_on, fundamental_hz, depth, dread, expression, velocity,
		input ready);
	modport sink(input valid, note_on, fundamental_hz, depth, dread, expression, velocity,
		output ready);
endinterface

interface cwv_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample_out;

	modport source(output valid, sample_out, input ready);
	modport sink(input valid, sample_out, output ready);
endinterface

>>> design/cwv_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cwv_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/coupled_waveguide_voice.sv
// Coupled waveguide voice: top level with sequencer, shared multiplier and tunnel RAM.
//
// Usage: one beat on in_ch per audio sample (note_on, pitch, four knobs) gives one
// beat on out_ch carrying sample_out. Configuration (sample rate, noise seed) is
// written through cfg_we/cfg_index/cfg_data; the user must write it only while the
// voice is idle, the block itself does not enforce this. A seed write also reloads
// the noise generator. Timing: an accepted audible tick runs a bit-serial period
// division producing 42 quotient bits, then 107 sequencer steps, each an issue and
// a write-back phase, on the single shared 34x34 multiplier (tanh interpolation and
// delay lengths included), then loads the output register, which raises out_ch.valid.
// A silent tick (zero pitch or sample rate at most 1) skips division and sequencer
// and goes straight to the done state, which loads a zero sample into the output
// register and returns to idle.
// in_ch.ready is high only while the sequencer is idle, so throughput is one tick
// per run; a finished sample sits in the output register, so the next tick is
// accepted while out_ch is stalled and only its completion waits for the sink.
// Reset: arst_n clears the control state and then a clearing pass writes zeros to
// all 16384 tunnel RAM entries, one per cycle; no tick is accepted during the pass,
// configuration writes are taken throughout.
module coupled_waveguide_voice
	import cwv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	cwv_in_if.sink      in_ch,
	cwv_out_if.source   out_ch
);

	typedef enum logic [2:0] {S_CLR, S_IDLE, S_DIV, S_RUN, S_DONE} state_t;

	typedef enum logic [6:0] {
		P_D2, P_LS, P_ASO, P_ASE, P_F1, P_F2, P_DL, P_EX, P_MEAN, P_JR,
		P_JL, P_RR, P_RL, P_O1, P_O2, P_O3, P_ONS, P_DK1, P_DK2, P_B1,
		P_B2, P_B3, P_BR, P_FB1, P_FB2, P_FB3, P_C1, P_C2, P_COMP, P_RW,
		P_CA, P_CB, P_G, P_H, P_CH, P_KK, P_RATE, P_WALL, P_SCAT, P_SF,
		P_ONDIV, P_CP1, P_CP2, P_CG, P_NX, P_WR, P_WS, P_PR, P_S1, P_S2,
		P_SUB, P_V1, P_V2, P_V3, P_V4, P_V5, P_V6, P_V7, P_V8, P_V9,
		P_V10, P_V11, P_Y1, P_Y2, P_Y
	} step_t;

	state_t                    state_q;
	step_t                     pc_q;
	logic                      ph_q;
	logic [TUN_W-1:0]          ti_q;
	logic [MEM_AW-1:0]         clr_q;
	logic [5:0]                div_cnt_q;
	logic                      ov_q;
	logic signed [15:0]        smp_q;
	logic signed [15:0]        y_q;

	// configuration and input latches
	logic [17:0]               sr_q;
	logic [22:0]               fq_q;
	logic [14:0]               d_q, dr_q, e_q, v_q;

	// architectural state
	logic [POS_W-1:0]          wpos_q;
	logic signed [15:0]        wall_q [TUNNEL_COUNT];
	logic signed [15:0]        ex_q [TUNNEL_COUNT];
	logic signed [15:0]        junc_q, rumb_q;
	logic [15:0]               imp_q;
	logic [31:0]               noise_q;

	// working registers
	wd_t d2_q, ls_q, aso_q, ase_q, f_q, sum_q, mean_q, t_q, s_q, onset_q, breath_q;
	wd_t fb_q, comp_q, rw_q, ca_q, cb_q, g_q, ch_q, kk_q, wsum_q, press_q, coup_q;
	wd_t acc_q, tx_q, sub_q, cave_q;
	logic [41:0]               quot_q;
	logic [22:0]               rem_q;
	logic [MEM_AW-1:0]         raddr_q;
	logic signed [67:0]        p_q;

	logic                      accept, silent;
	wd_t                       op_a, op_b, r, d_w, dr_w, e_w, v_w, nd_w, ndr_w;
	logic [31:0]               period_w;
	logic [67:0]               mag, rnd;
	logic [67:0]               dsum;
	logic [POS_W-1:0]          dl;
	logic [23:0]               rem_n, rem_sub;
	logic                      ge;
	logic [31:0]               xs1, xs2, xs3;
	wd_t                       n_w, diff_w, absd_w, fb_sum;
	logic [WD_W-1:0]           ax;
	logic [17:0]               th_m;
	logic [5:0]                th_idx;
	logic [11:0]               th_frac;
	wd_t                       th_diff, th_mag;
	logic [67:0]               th_rnd;
	logic signed [15:0]        th_y;
	logic                      ram_we;
	logic [MEM_AW-1:0]         ram_waddr;
	logic [15:0]               ram_wdata, ram_rdata;

	assign accept = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE);
	assign silent = (in_ch.fundamental_hz == 23'd0) || (sr_q <= 18'd1);
	assign out_ch.valid = ov_q;
	assign out_ch.sample_out = smp_q;

	assign d_w   = wd_t'({1'b0, d_q});
	assign dr_w  = wd_t'({1'b0, dr_q});
	assign e_w   = wd_t'({1'b0, e_q});
	assign v_w   = wd_t'({1'b0, v_q});
	assign nd_w  = wd_t'(Q_ONE) - d_w;
	assign ndr_w = wd_t'(Q_ONE) - dr_w;

	// period in Q16 samples, capped to 32 bits
	assign period_w = (|quot_q[41:32]) ? 32'hFFFF_FFFF : quot_q[31:0];

	// restoring division step
	assign rem_n   = {rem_q, quot_q[41]};
	assign rem_sub = rem_n - {1'b0, fq_q};
	assign ge      = (rem_n >= {1'b0, fq_q});

	// Q15 product rounded half away from zero
	assign mag = p_q[67] ? 68'(-p_q) : 68'(p_q);
	assign rnd = mag + 68'd16384;
	assign r   = p_q[67] ? -wd_t'(rnd[48:15]) : wd_t'(rnd[48:15]);

	// delay length from period*f
	assign dsum = 68'(p_q) + (68'd1 << 30);
	always_comb begin
		if (dsum[67:31] > 37'(DELAY_DEPTH - 1)) begin
			dl = POS_W'(DELAY_DEPTH - 1);
		end else if (dsum[67:31] < 37'd8) begin
			dl = POS_W'(8);
		end else begin
			dl = dsum[POS_W+30:31];
		end
	end

	// xorshift32 step and noise sample
	assign xs1 = noise_q ^ (noise_q << 13);
	assign xs2 = xs1 ^ (xs1 >> 17);
	assign xs3 = xs2 ^ (xs2 << 5);
	assign n_w = wd_t'({2'b0, noise_q[31:16]}) - wd_t'(Q_ONE);

	assign diff_w = wd_t'(ex_q[ti_q]) - wd_t'(wall_q[ti_q]);
	assign absd_w = diff_w[WD_W-1] ? -diff_w : diff_w;
	assign fb_sum = fb_q + r;

	// tanh: table lookup, interpolation product on the shared multiplier
	assign ax      = tx_q[WD_W-1] ? WD_W'(-tx_q) : WD_W'(tx_q);
	assign th_m    = (ax > WD_W'(TANH_TOP)) ? 18'(TANH_TOP) : ax[17:0];
	assign th_idx  = th_m[17:12];
	assign th_frac = th_m[11:0];
	assign th_diff = (th_idx == 6'd32) ? wd_t'(0) :
		wd_t'(tanh_tab(th_idx + 6'd1)) - wd_t'(tanh_tab(th_idx));
	assign th_rnd  = 68'(p_q) + 68'd2048;
	assign th_mag  = wd_t'(tanh_tab(th_idx)) + wd_t'(th_rnd[WD_W+11:12]);
	assign th_y    = tx_q[WD_W-1] ? -$signed(th_mag[15:0]) : $signed(th_mag[15:0]);

	// operand select for the shared multiplier
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (pc_q)
			P_D2:    begin op_a = d_w;               op_b = d_w;            end
			P_LS:    begin op_a = wd_t'(46531);      op_b = d2_q;           end
			P_ASO:   begin op_a = wd_t'(3604);       op_b = dr_w;           end
			P_ASE:   begin op_a = wd_t'(2294);       op_b = dr_w;           end
			P_F1:    begin op_a = len_ratio(ti_q);   op_b = ls_q;           end
			P_F2:    begin op_a = t_q;               op_b = ti_q[0] ? aso_q : ase_q; end
			P_DL:    begin op_a = wd_t'({2'b0, period_w}); op_b = f_q;      end
			P_MEAN:  begin op_a = sum_q;             op_b = wd_t'(8192);    end
			P_JR:    begin op_a = wd_t'(2294);       op_b = ndr_w;          end
			P_JL:    begin op_a = t_q;               op_b = mean_q - wd_t'(junc_q); end
			P_RR:    begin op_a = wd_t'(131);        op_b = nd_w;           end
			P_RL:    begin op_a = t_q;               op_b = n_w - wd_t'(rumb_q); end
			P_O1:    begin op_a = wd_t'(7864);       op_b = v_w;            end
			P_O2:    begin op_a = wd_t'({2'b0, imp_q}); op_b = t_q;         end
			P_O3:    begin op_a = wd_t'(14746);      op_b = e_w;            end
			P_ONS:   begin op_a = t_q;               op_b = s_q;            end
			P_DK1:   begin op_a = wd_t'(15);         op_b = d_w;            end
			P_DK2:   begin op_a = wd_t'({2'b0, imp_q}); op_b = t_q;         end
			P_B1:    begin op_a = wd_t'(1638);       op_b = e_w;            end
			P_B2:    begin op_a = wd_t'(26214);      op_b = d_w;            end
			P_B3:    begin op_a = wd_t'(rumb_q);     op_b = t_q;            end
			P_BR:    begin op_a = t_q;               op_b = s_q;            end
			P_FB1:   begin op_a = wd_t'(6881);       op_b = dr_w;           end
			P_FB2:   begin op_a = wd_t'(1966);       op_b = e_w;            end
			P_FB3:   begin op_a = wd_t'(655);        op_b = d_w;            end
			P_C1:    begin op_a = wd_t'(91750);      op_b = dr_w;           end
			P_C2:    begin op_a = sat20(wd_t'(junc_q) + mean_q); op_b = t_q; end
			P_COMP:  begin op_a = th_diff;           op_b = wd_t'(th_frac); end
			P_RW:    begin op_a = wd_t'(5898);       op_b = ndr_w;          end
			P_CA:    begin op_a = wd_t'(7864);       op_b = d2_q;           end
			P_CB:    begin op_a = wd_t'(2294);       op_b = dr_w;           end
			P_G:     begin op_a = wd_t'(19005);      op_b = e_w;            end
			P_H:     begin op_a = wd_t'(4588);       op_b = dr_w;           end
			P_CH:    begin op_a = comp_q;            op_b = t_q;            end
			P_KK:    begin op_a = wd_t'(10486);      op_b = dr_w;           end
			P_RATE:  begin op_a = rw_q;              op_b = recip(ti_q);    end
			P_WALL:  begin op_a = t_q;               op_b = diff_w;         end
			P_SCAT:  begin op_a = (mean_q <<< 1) - wd_t'(ex_q[ti_q]); op_b = fb_q; end
			P_SF:    begin op_a = t_q;               op_b = scat_gain(ti_q); end
			P_ONDIV: begin op_a = onset_q;           op_b = recip(ti_q);    end
			P_CP1:   begin op_a = ca_q;              op_b = wd_t'(ex_q[ti_q + 2'd1]); end
			P_CP2:   begin op_a = cb_q;              op_b = wd_t'(ex_q[ti_q + 2'd2]); end
			P_CG:    begin op_a = coup_q;            op_b = g_q;            end
			P_NX:    begin op_a = acc_q;             op_b = kk_q;           end
			P_WR:    begin op_a = th_diff;           op_b = wd_t'(th_frac); end
			P_WS:    begin op_a = wsum_q;            op_b = wd_t'(8192);    end
			P_PR:    begin op_a = press_q;           op_b = wd_t'(8192);    end
			P_S1:    begin op_a = wd_t'(72090);      op_b = d_w;            end
			P_S2:    begin op_a = mean_q - wsum_q;   op_b = t_q;            end
			P_SUB:   begin op_a = th_diff;           op_b = wd_t'(th_frac); end
			P_V1:    begin op_a = wd_t'(10486);      op_b = e_w;            end
			P_V2:    begin op_a = mean_q;            op_b = t_q;            end
			P_V3:    begin op_a = wd_t'(15729);      op_b = dr_w;           end
			P_V4:    begin op_a = wsum_q;            op_b = t_q;            end
			P_V5:    begin op_a = wd_t'(13763);      op_b = d_w;            end
			P_V6:    begin op_a = wd_t'(junc_q);     op_b = t_q;            end
			P_V7:    begin op_a = d_w;               op_b = dr_w;           end
			P_V8:    begin op_a = wd_t'(9830);       op_b = t_q;            end
			P_V9:    begin op_a = sub_q;             op_b = t_q;            end
			P_V10:   begin op_a = wd_t'(3932);       op_b = press_q;        end
			P_V11:   begin op_a = wd_t'(rumb_q);     op_b = t_q;            end
			P_Y1:    begin op_a = wd_t'(22938);      op_b = dr_w;           end
			P_Y2:    begin op_a = cave_q;            op_b = t_q;            end
			P_Y:     begin op_a = th_diff;           op_b = wd_t'(th_frac); end
			default: begin op_a = '0;                op_b = '0;             end
		endcase
	end

	// shared multiplier, product registered in the issue phase
	always_ff @(posedge clk) begin
		if (!ph_q) begin
			p_q <= op_a * op_b;
		end
	end

	// tunnel RAM: clearing pass after reset, else one write per tunnel per audible tick
	assign ram_we    = (state_q == S_CLR) || (state_q == S_RUN && ph_q && pc_q == P_WR);
	assign ram_waddr = (state_q == S_CLR) ? clr_q : {ti_q, wpos_q};
	assign ram_wdata = (state_q == S_CLR) ? 16'd0 : th_y;

	cwv_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(MEM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(raddr_q),
		.rdata(ram_rdata)
	);

	// sequencer: state, step counter and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			pc_q      <= P_D2;
			ph_q      <= 1'b0;
			ti_q      <= '0;
			clr_q     <= '0;
			div_cnt_q <= '0;
			ov_q      <= 1'b0;
			smp_q     <= '0;
			y_q       <= '0;
		end else begin
			if (ov_q && out_ch.ready && state_q != S_DONE) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == MEM_AW'(MEM_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (silent) begin
							y_q     <= '0;
							state_q <= S_DONE;
						end else begin
							div_cnt_q <= '0;
							state_q   <= S_DIV;
						end
					end
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 6'd1;
					if (div_cnt_q == 6'd41) begin
						pc_q    <= P_D2;
						ph_q    <= 1'b0;
						ti_q    <= '0;
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if ((pc_q == P_EX || pc_q == P_WR) && ti_q != TUN_W'(TUNNEL_COUNT - 1)) begin
							ti_q <= ti_q + 1'b1;
							pc_q <= (pc_q == P_EX) ? P_F1 : P_RATE;
						end else if (pc_q == P_Y) begin
							y_q     <= th_y;
							state_q <= S_DONE;
						end else begin
							// tunnel index restarts only when a per-tunnel loop ends
							if (pc_q == P_EX || pc_q == P_WR) begin
								ti_q <= '0;
							end
							pc_q <= step_t'(pc_q + 7'd1);
						end
					end
				end
				S_DONE: begin
					if (!ov_q || out_ch.ready) begin
						ov_q    <= 1'b1;
						smp_q   <= y_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers and step write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sr_q    <= SR_RESET;
			noise_q <= SEED_RESET;
			wpos_q  <= '0;
			junc_q  <= '0;
			rumb_q  <= '0;
			imp_q   <= '0;
			for (int i = 0; i < TUNNEL_COUNT; i++) begin
				wall_q[i] <= '0;
				ex_q[i]   <= '0;
			end
			fq_q <= '0; d_q <= '0; dr_q <= '0; e_q <= '0; v_q <= '0;
			quot_q <= '0; rem_q <= '0; raddr_q <= '0;
			d2_q <= '0; ls_q <= '0; aso_q <= '0; ase_q <= '0; f_q <= '0; sum_q <= '0;
			mean_q <= '0; t_q <= '0; s_q <= '0; onset_q <= '0; breath_q <= '0;
			fb_q <= '0; comp_q <= '0; rw_q <= '0; ca_q <= '0; cb_q <= '0; g_q <= '0;
			ch_q <= '0; kk_q <= '0; wsum_q <= '0; press_q <= '0; coup_q <= '0;
			acc_q <= '0; tx_q <= '0; sub_q <= '0; cave_q <= '0;
		end else begin
			// configuration writes
			if (cfg_we) begin
				case (cfg_index)
					CFG_SAMPLE_RATE: sr_q    <= cfg_data[17:0];
					CFG_NOISE_SEED:  noise_q <= cfg_data;
					default: ;
				endcase
			end

			// tick accept: latch fields, load impulse on note_on, set up division
			if (accept) begin
				if (in_ch.note_on) begin
					imp_q <= 16'(Q_ONE);
				end
				fq_q    <= in_ch.fundamental_hz;
				d_q     <= in_ch.depth[15:1];
				dr_q    <= in_ch.dread[15:1];
				e_q     <= in_ch.expression[15:1];
				v_q     <= in_ch.velocity[15:1];
				quot_q  <= {sr_q, 24'd0};
				rem_q   <= '0;
				sum_q   <= '0;
				wsum_q  <= '0;
				press_q <= '0;
			end

			if (state_q == S_DIV) begin
				quot_q <= {quot_q[40:0], ge};
				rem_q  <= ge ? rem_sub[22:0] : rem_n[22:0];
			end

			if (state_q == S_RUN && ph_q) begin
				case (pc_q)
					P_D2:    d2_q  <= r;
					P_LS:    ls_q  <= wd_t'(19005) + r;
					P_ASO:   aso_q <= wd_t'(Q_ONE) + r;
					P_ASE:   ase_q <= wd_t'(Q_ONE) - r;
					P_F1:    t_q   <= r;
					P_F2:    f_q   <= r;
					P_DL:    raddr_q <= {ti_q, wpos_q - dl};
					P_EX: begin
						ex_q[ti_q] <= $signed(ram_rdata);
						sum_q      <= sum_q + wd_t'($signed(ram_rdata));
					end
					P_MEAN:  mean_q <= r;
					P_JR:    t_q    <= wd_t'(197) + r;
					P_JL: begin
						junc_q  <= sat16(wd_t'(junc_q) + r);
						noise_q <= xs3;
					end
					P_RR:    t_q    <= wd_t'(23) + r;
					P_RL:    rumb_q <= sat16(wd_t'(rumb_q) + r);
					P_O1:    t_q    <= wd_t'(1638) + r;
					P_O2:    t_q    <= r;
					P_O3:    s_q    <= wd_t'(18022) + r;
					P_ONS:   onset_q <= r;
					P_DK1:   t_q    <= wd_t'(32750) - r;
					P_DK2:   imp_q  <= p_q[30:15];
					P_B1:    t_q    <= wd_t'(131) + r;
					P_B2:    s_q    <= wd_t'(19661) + r;
					P_B3:    t_q    <= r;
					P_BR:    breath_q <= r;
					P_FB1:   fb_q   <= wd_t'(22282) + r;
					P_FB2:   fb_q   <= fb_q + r;
					P_FB3:   fb_q   <= (fb_sum > wd_t'(FB_CAP)) ? wd_t'(FB_CAP) : fb_sum;
					P_C1:    t_q    <= wd_t'(19661) + r;
					P_C2:    tx_q   <= sat20(r);
					P_COMP:  comp_q <= wd_t'(th_y);
					P_RW:    rw_q   <= r;
					P_CA:    ca_q   <= wd_t'(819) + r;
					P_CB:    cb_q   <= wd_t'(328) + r;
					P_G:     g_q    <= wd_t'(10486) + r;
					P_H:     t_q    <= wd_t'(655) + r;
					P_CH:    ch_q   <= r;
					P_KK:    kk_q   <= wd_t'(Q_ONE) + r;
					P_RATE:  t_q    <= wd_t'(197) + wd_t'(p_q[WD_W+15:16]);
					P_WALL:  wall_q[ti_q] <= sat16(wd_t'(wall_q[ti_q]) + r);
					P_SCAT: begin
						t_q     <= r;
						wsum_q  <= wsum_q + wd_t'(wall_q[ti_q]);
						press_q <= press_q + absd_w;
					end
					P_SF:    acc_q  <= ch_q + breath_q + r;
					P_ONDIV: acc_q  <= acc_q + wd_t'(p_q[WD_W+15:16]);
					P_CP1:   coup_q <= r;
					P_CP2:   coup_q <= coup_q - r;
					P_CG:    acc_q  <= sat20(acc_q + r);
					P_NX:    tx_q   <= r;
					P_WS: begin
						wsum_q <= r;
						wpos_q <= wpos_q + 1'b1;
					end
					P_PR:    press_q <= r;
					P_S1:    t_q    <= wd_t'(36045) + r;
					P_S2:    tx_q   <= sat20(r);
					P_SUB:   sub_q  <= wd_t'(th_y);
					P_V1:    t_q    <= wd_t'(12452) + r;
					P_V2:    cave_q <= r;
					P_V3:    t_q    <= wd_t'(15729) + r;
					P_V4:    cave_q <= cave_q + r;
					P_V5:    t_q    <= wd_t'(5243) + r;
					P_V6:    cave_q <= cave_q + r;
					P_V7:    t_q    <= r;
					P_V8:    t_q    <= wd_t'(2621) + r;
					P_V9:    cave_q <= cave_q + r;
					P_V10:   t_q    <= wd_t'(983) + r;
					P_V11:   cave_q <= sat20(cave_q + r);
					P_Y1:    t_q    <= wd_t'(50790) + r;
					P_Y2:    tx_q   <= sat20(r);
					default: ;
				endcase
			end
		end
	end

`ifndef SYNTH
	// an accepted tick always leaves the idle state
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("tick accepted but sequencer stayed idle");

	// the write position moves only in the P_WS step of an audible tick, after the tunnel writes
	a_wpos_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(wpos_q) |-> $past(state_q == S_RUN && ph_q && pc_q == P_WS))
		else $error("write position moved outside its step");

	// an audible tick always has a nonzero period
	a_period: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RUN |-> period_w != 32'd0)
		else $error("zero period during run");

	// tunnel RAM is never written while exits are being read
	a_no_wr_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN && (pc_q == P_DL || pc_q == P_EX)) |-> !ram_we)
		else $error("tunnel write during exit read");
`endif

endmodule

>>> verif/coupled_waveguide_voice_tb.sv
// Self-checking testbench for the coupled waveguide voice: directed and random ticks checked against a predictor.
`timescale 1ns / 100ps

module coupled_waveguide_voice_tb;
	import cwv_pkg::*;

	localparam int TANH_PTS [33] = '{
		0, 4075, 8026, 11743, 15143, 18173, 20813, 23079, 24956,
		26519, 27797, 28830, 29660, 30322, 30847, 31262, 31589,
		31846, 32048, 32205, 32329, 32426, 32502, 32560, 32606,
		32642, 32670, 32691, 32708, 32722, 32732, 32740, 32746
	};
	localparam int TUN_RATIO [4] = '{13435, 23265, 40305, 63242};
	localparam longint LIM20     = 1048576;
	localparam int DRAIN_CYCLES  = 400;
	localparam int CYCLE_LIMIT   = 1500000;
	localparam int HOLD_CYCLES   = 3000;

	typedef struct {
		logic        note_on;
		logic [22:0] fundamental_hz;
		logic [15:0] depth;
		logic [15:0] dread;
		logic [15:0] expression;
		logic [15:0] velocity;
	} tick_t;

	// Voice predictor and queue of expected samples
	class voice_scoreboard;
		shortint     tunnel [4][DELAY_DEPTH];
		int          wr_pos [4];
		longint      wall [4];
		longint      junction, rumble, env;
		logic [31:0] noise;
		int          rate_hz;
		shortint     expected_samples [$];
		int          errors;

		function new();
			foreach (tunnel[i, j]) tunnel[i][j] = 0;
			foreach (wr_pos[i]) begin
				wr_pos[i] = 0;
				wall[i] = 0;
			end
			junction = 0;
			rumble = 0;
			env = 0;
			rate_hz = 48000;
			noise = 32'd2463534242;
			errors = 0;
		endfunction

		function void set_rate(logic [31:0] val);
			rate_hz = int'(val[17:0]);
		endfunction

		function void set_seed(logic [31:0] val);
			noise = val;
		endfunction

		static function longint sat(longint x, longint lim);
			if (x > lim - 1) return lim - 1;
			if (x < -lim) return -lim;
			return x;
		endfunction

		// Q15 product, rounded half away from zero
		static function longint mq(longint a, longint b);
			longint p;
			p = a * b;
			if (p >= 0) return (p + 16384) >>> 15;
			return -((-p + 16384) >>> 15);
		endfunction

		static function longint th(longint x);
			longint m, y;
			int idx, frac;
			m = (x < 0) ? -x : x;
			if (m > 131072) m = 131072;
			idx = int'(m >>> 12);
			frac = int'(m & 4095);
			if (idx >= 32) y = TANH_PTS[32];
			else y = TANH_PTS[idx]
				+ (((TANH_PTS[idx + 1] - TANH_PTS[idx]) * frac + 2048) >>> 12);
			return (x < 0) ? -y : y;
		endfunction

		function void note_tick(tick_t t);
			longint d, dr, e, v, d2, ls, period, asym, f, dl, sum, mean, n;
			longint onset, breath, fb, comp, rate, diff, scat, coup, nxt;
			longint wsum, press, sub, cave, y;
			longint ex [4];
			int rd, wp;
			d = t.depth >> 1;
			dr = t.dread >> 1;
			e = t.expression >> 1;
			v = t.velocity >> 1;
			sum = 0;
			wsum = 0;
			press = 0;
			if (t.note_on) env = 32768;
			// silent pitch or sample rate: nothing else moves
			if (t.fundamental_hz == 0 || rate_hz <= 1) begin
				expected_samples.push_back(0);
				return;
			end
			period = (longint'(rate_hz) << 24) / longint'(t.fundamental_hz);
			if (period > 64'hFFFF_FFFF) period = 64'hFFFF_FFFF;
			d2 = mq(d, d);
			ls = 19005 + mq(46531, d2);
			// read tunnel exits
			for (int i = 0; i < 4; i++) begin
				asym = (i & 1) ? 32768 + mq(3604, dr) : 32768 - mq(2294, dr);
				f = mq(mq(TUN_RATIO[i], ls), asym);
				dl = (period * f + (64'd1 << 30)) >> 31;
				if (dl < 8) dl = 8;
				if (dl > DELAY_DEPTH - 1) dl = DELAY_DEPTH - 1;
				rd = int'((wr_pos[i] + DELAY_DEPTH - dl) % DELAY_DEPTH);
				ex[i] = tunnel[i][rd];
				sum += ex[i];
			end
			mean = mq(sum, 8192);
			junction = sat(junction + mq(197 + mq(2294, 32768 - dr), mean - junction), 32768);
			noise ^= noise << 13;
			noise ^= noise >> 17;
			noise ^= noise << 5;
			n = longint'(noise >> 16) - 32768;
			rumble = sat(rumble + mq(23 + mq(131, 32768 - d), n - rumble), 32768);
			onset = mq(mq(env, 1638 + mq(7864, v)), 18022 + mq(14746, e));
			env = (env * (32750 - mq(15, d))) >>> 15;
			breath = mq(mq(rumble, 131 + mq(1638, e)), 19661 + mq(26214, d));
			fb = 22282 + mq(6881, dr) + mq(1966, e) + mq(655, d);
			if (fb > 32178) fb = 32178;
			comp = th(sat(mq(sat(junction + mean, LIM20), 19661 + mq(91750, dr)), LIM20));
			// walls, scattering, coupling and write-back
			for (int i = 0; i < 4; i++) begin
				rate = 197 + mq(5898, 32768 - dr) / (i + 1);
				wp = wr_pos[i] % DELAY_DEPTH;
				wall[i] = sat(wall[i] + mq(rate, ex[i] - wall[i]), 32768);
				wsum += wall[i];
				diff = ex[i] - wall[i];
				press += (diff < 0) ? -diff : diff;
				scat = 2 * mean - ex[i];
				coup = mq(819 + mq(7864, d2), ex[(i + 1) % 4])
					- mq(328 + mq(2294, dr), ex[(i + 2) % 4]);
				nxt = sat(onset / (i + 1) + breath + mq(mq(scat, fb), 28180 - 2294 * i)
					+ mq(coup, 10486 + mq(19005, e)) + mq(comp, 655 + mq(4588, dr)), LIM20);
				tunnel[i][wp] = shortint'(sat(th(mq(nxt, 32768 + mq(10486, dr))), 32768));
				wr_pos[i] = (wp + 1) % DELAY_DEPTH;
			end
			wsum = mq(wsum, 8192);
			press = mq(press, 8192);
			sub = th(sat(mq(mean - wsum, 36045 + mq(72090, d)), LIM20));
			cave = sat(mq(mean, 12452 + mq(10486, e)) + mq(wsum, 15729 + mq(15729, dr))
				+ mq(junction, 5243 + mq(13763, d)) + mq(sub, 2621 + mq(9830, mq(d, dr)))
				+ mq(rumble, 983 + mq(3932, press)), LIM20);
			y = th(sat(mq(cave, 50790 + mq(22938, dr)), LIM20));
			expected_samples.push_back(shortint'(y));
		endfunction

		function void check_sample(logic signed [15:0] got);
			shortint want;
			if (expected_samples.size() == 0) begin
				$error("sample_out: unexpected beat, actual %0d", got);
				errors++;
				return;
			end
			want = expected_samples.pop_front();
			if (got !== want) begin
				$error("sample_out: expected %0d, actual %0d", want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [31:0] cfg_data;
	cwv_in_if in_ch();
	cwv_out_if out_ch();

	voice_scoreboard sb = new();
	bit long_hold_req = 1'b0;
	bit calm = 1'b0;
	int unsigned cycles = 0;

	coupled_waveguide_voice u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	always #1 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic int draw_gap();
		if (calm) return 0;
		return $urandom_range(0, 11);
	endfunction

	// Output side: random stalls, one long hold on request
	initial begin
		int w;
		out_ch.ready = 1'b0;
		@(posedge clk);
		forever begin
			w = draw_gap();
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				w = HOLD_CYCLES;
			end
			if (w > 0) begin
				out_ch.ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			sb.check_sample(out_ch.sample_out);
		end
	end

	task automatic write_regs(logic [31:0] rate, logic [31:0] seed);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SAMPLE_RATE;
		cfg_data <= rate;
		@(posedge clk);
		cfg_index <= CFG_NOISE_SEED;
		cfg_data <= seed;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_rate(rate);
		sb.set_seed(seed);
	endtask

	task automatic send_tick(tick_t t);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.note_on <= t.note_on;
		in_ch.fundamental_hz <= t.fundamental_hz;
		in_ch.depth <= t.depth;
		in_ch.dread <= t.dread;
		in_ch.expression <= t.expression;
		in_ch.velocity <= t.velocity;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_tick(t);
	endtask

	function automatic tick_t make_tick(bit on, int hz, int dp, int dr, int ex, int vel);
		tick_t t;
		t.note_on = on;
		t.fundamental_hz = 23'(hz);
		t.depth = 16'(dp);
		t.dread = 16'(dr);
		t.expression = 16'(ex);
		t.velocity = 16'(vel);
		return t;
	endfunction

	// mostly played notes, some full-range pitch and some silence
	function automatic tick_t rand_tick();
		int sel, hz;
		sel = $urandom_range(0, 19);
		if (sel == 0) hz = 0;
		else if (sel <= 3) hz = $urandom_range(1, 5242879);
		else hz = $urandom_range(20 * 256, 2000 * 256);
		return make_tick($urandom_range(0, 15) == 0, hz, $urandom_range(0, 65535),
			$urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535));
	endfunction

	task automatic run_random(int count);
		for (int k = 0; k < count; k++) begin
			if (k % 40 == 0) calm = ($urandom_range(0, 3) == 0);
			send_tick(rand_tick());
		end
	endtask

	// wait for every sample, then idle the input for a drain period
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sb.expected_samples.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_SAMPLE_RATE;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.note_on = 1'b0;
		in_ch.fundamental_hz = '0;
		in_ch.depth = '0;
		in_ch.dread = '0;
		in_ch.expression = '0;
		in_ch.velocity = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_regs(32'd48000, 32'd2463534242);

		// directed: field extremes, silent pitch, note starts, long and short delays
		send_tick(make_tick(1, 440 * 256, 0, 0, 0, 0));
		send_tick(make_tick(0, 440 * 256, 0, 0, 0, 0));
		send_tick(make_tick(1, 0, 65535, 65535, 65535, 65535));
		send_tick(make_tick(0, 0, 0, 0, 0, 0));
		send_tick(make_tick(0, 110 * 256, 65535, 65535, 65535, 65535));
		send_tick(make_tick(1, 1, 65535, 0, 65535, 65535));
		send_tick(make_tick(0, 1, 0, 65535, 0, 0));
		send_tick(make_tick(1, 5242879, 0, 65535, 65535, 65535));
		send_tick(make_tick(0, 5242879, 65535, 0, 0, 65535));
		send_tick(make_tick(1, 4194304, 32768, 32768, 32768, 32768));
		send_tick(make_tick(1, 55 * 256, 65535, 65535, 65535, 65535));
		for (int k = 0; k < 12; k++)
			send_tick(make_tick(k == 0, 1000 * 256 + k, 65535, 65535, 65535, 65535));
		run_random(300);
		drain();

		// fastest rate, all-ones seed; output held off for a long stretch
		write_regs(32'd192000, 32'hFFFF_FFFF);
		long_hold_req = 1'b1;
		run_random(250);
		drain();

		// slowest audible rate, zero seed
		write_regs(32'd8000, 32'd0);
		run_random(250);
		drain();

		// sample rate of one: all silent
		write_regs(32'd1, 32'd1);
		run_random(30);
		drain();

		write_regs(32'd96000, 32'd1);
		run_random(220);
		drain();

		if (sb.errors == 0 && sb.expected_samples.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

>>> sim.f
design/cwv_pkg.sv
design/cwv_if.sv
design/cwv_ram.sv
design/coupled_waveguide_voice.sv
verif/coupled_waveguide_voice_tb.sv
